/* rtl/core/gamepad_drive_command_mapper_macros.svh */
// Assertion macros used by the gamepad drive command mapper datapath.
`ifndef GAMEPAD_DRIVE_COMMAND_MAPPER_MACROS_SVH
`define GAMEPAD_DRIVE_COMMAND_MAPPER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GDCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define GDCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gdcm_pkg.sv */
// Types, constants and helper functions of the gamepad drive command mapper.
`timescale 1ns / 1ps

package gdcm_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int DEADZONE_W  = 9;
  localparam int GAIN_STEP_W = 8;
  localparam int GAIN_W      = 12;
  localparam int MODE_W      = 3;
  localparam int CMD_W       = 16;
  localparam int RAW_W       = 10;
  localparam int MAG_W       = 9;
  localparam int PROD_W      = MAG_W + GAIN_W;
  localparam int NUM_BUTTONS = 5;

  localparam int STICK_SPAN     = 1000;
  localparam int CMD_LIMIT      = 500;
  localparam int TRIG_THRESHOLD = 10;
  localparam int TRIG_FULL      = 255;
  // 257 / 65536 approximates 1 / 255 from below.
  localparam int RECIP_255      = 257;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [DEADZONE_W-1:0]  DEADZONE_RST     = 9'd50;
  localparam logic [GAIN_STEP_W-1:0] GAIN_STEP_RST    = 8'd26;
  localparam logic [GAIN_W-1:0]      GAIN_MIN_RST     = 12'd26;
  localparam logic [GAIN_W-1:0]      GAIN_MAX_RST     = 12'd512;
  localparam logic [GAIN_W-1:0]      GAIN_UNITY       = 12'd256;
  localparam logic [MODE_W-1:0]      DEFAULT_MODE_RST = 3'd1;
  localparam logic [MODE_W-1:0]      MODE_MAX_RST     = 3'd3;

  // Drive modes with a fixed meaning.
  localparam logic [MODE_W-1:0] MODE_DUAL_STICK = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT_STICK = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRIGGER    = 3'd3;

  // Button bit positions.
  localparam int BTN_TOUCH      = 0;
  localparam int BTN_SPEED_UP   = 1;
  localparam int BTN_SPEED_DOWN = 2;
  localparam int BTN_STEER_UP   = 3;
  localparam int BTN_STEER_DOWN = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE     = 3'd0,
    CFG_GAIN_STEP    = 3'd1,
    CFG_GAIN_MIN     = 3'd2,
    CFG_GAIN_MAX     = 3'd3,
    CFG_DEFAULT_MODE = 3'd4,
    CFG_MODE_MAX     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LED_RED   = 2'd0,
    LED_GREEN = 2'd1,
    LED_BLUE  = 2'd2,
    LED_OFF   = 2'd3
  } led_color_e;

  // One gamepad report as it arrives on the input stream.
  typedef struct packed {
    logic                   connect_event;
    logic [NUM_BUTTONS-1:0] buttons;
    logic [7:0]             right_trigger;
    logic [7:0]             left_trigger;
    logic signed [7:0]      right_x;
    logic signed [7:0]      left_y;
    logic signed [7:0]      left_x;
  } gdcm_report_t;

  // A classified report: state already applied, ready for the datapath.
  typedef struct packed {
    logic                   connect_event;
    logic                   led_update;
    logic [MODE_W-1:0]      mode;
    logic [GAIN_W-1:0]      steer_gain;
    logic [GAIN_W-1:0]      speed_gain;
    logic [7:0]             right_trigger;
    logic [7:0]             left_trigger;
    logic signed [7:0]      right_x;
    logic signed [7:0]      left_y;
    logic signed [7:0]      left_x;
  } gdcm_item_t;

  typedef struct packed {
    logic              connect_event;
    logic              led_update;
    logic [MODE_W-1:0] mode;
    logic [GAIN_W-1:0] steer_gain;
    logic [GAIN_W-1:0] speed_gain;
  } gdcm_meta_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] steer_cmd;
    logic signed [CMD_W-1:0] speed_cmd;
    logic                    drive_valid;
    logic [MODE_W-1:0]       drive_mode;
    logic                    led_update;
    led_color_e              led_color;
  } gdcm_result_t;

  // Stick position to command: (v + 128) * 1000 / 256 - 500.
  function automatic logic signed [RAW_W-1:0] map_stick(input logic signed [7:0] v);
    logic [7:0]        u;
    logic [17:0]       p;
    logic signed [10:0] t;
    u = {~v[7], v[6:0]};
    p = 18'(u) * 18'(STICK_SPAN);
    t = $signed({1'b0, p[17:8]}) - 11'(CMD_LIMIT);
    return t[RAW_W-1:0];
  endfunction

  // Trigger value to command magnitude: x * 500 / 255, by reciprocal and one fix-up.
  function automatic logic [MAG_W-1:0] trig_map(input logic [7:0] x);
    logic [16:0] y;
    logic [25:0] p;
    logic [9:0]  q0;
    logic [16:0] r;
    logic [9:0]  q;
    y  = 17'(x) * 17'(CMD_LIMIT);
    p  = 26'(y) * 26'(RECIP_255);
    q0 = p[25:16];
    r  = y - 17'(q0) * 17'(TRIG_FULL);
    q  = (r >= 17'(TRIG_FULL)) ? q0 + 10'd1 : q0;
    return q[MAG_W-1:0];
  endfunction

endpackage

/* rtl/core/gdcm_front.sv */
// Front end: configuration registers, button edges, mode and gain state.
`timescale 1ns / 1ps

module gdcm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gdcm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gdcm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  input  gdcm_pkg::gdcm_report_t            in_data_i,
  output logic                              in_ready_o,
  input  logic                              fifo_full_i,
  output logic                              push_o,
  output gdcm_pkg::gdcm_item_t              item_o,
  output logic [gdcm_pkg::DEADZONE_W-1:0]   deadzone_o
);

  logic [gdcm_pkg::DEADZONE_W-1:0]  deadzone_q;
  logic [gdcm_pkg::GAIN_STEP_W-1:0] gain_step_q;
  logic [gdcm_pkg::GAIN_W-1:0]      gain_min_q, gain_max_q;
  logic [gdcm_pkg::MODE_W-1:0]      default_mode_q, mode_max_q;

  logic [gdcm_pkg::MODE_W-1:0]      mode_q, mode_d;
  logic [gdcm_pkg::GAIN_W-1:0]      speed_gain_q, speed_gain_d;
  logic [gdcm_pkg::GAIN_W-1:0]      steer_gain_q, steer_gain_d;
  logic [gdcm_pkg::NUM_BUTTONS-1:0] held_q, held_d;

  logic                             accept;
  logic                             led;
  logic [gdcm_pkg::NUM_BUTTONS-1:0] rise;
  logic [gdcm_pkg::MODE_W:0]        mode_inc;

  function automatic logic [gdcm_pkg::GAIN_W-1:0] gain_up(
    input logic [gdcm_pkg::GAIN_W-1:0]      g,
    input logic [gdcm_pkg::GAIN_STEP_W-1:0] s,
    input logic [gdcm_pkg::GAIN_W-1:0]      mx
  );
    logic [gdcm_pkg::GAIN_W:0] v;
    v = {1'b0, g} + (gdcm_pkg::GAIN_W + 1)'(s);
    return (v > {1'b0, mx}) ? mx : v[gdcm_pkg::GAIN_W-1:0];
  endfunction

  function automatic logic [gdcm_pkg::GAIN_W-1:0] gain_down(
    input logic [gdcm_pkg::GAIN_W-1:0]      g,
    input logic [gdcm_pkg::GAIN_STEP_W-1:0] s,
    input logic [gdcm_pkg::GAIN_W-1:0]      mn
  );
    logic signed [gdcm_pkg::GAIN_W+1:0] v;
    v = $signed({2'b00, g}) - $signed((gdcm_pkg::GAIN_W + 2)'(s));
    return (v < $signed({2'b00, mn})) ? mn : v[gdcm_pkg::GAIN_W-1:0];
  endfunction

  assign accept     = in_valid_i && !fifo_full_i;
  assign in_ready_o = !fifo_full_i;
  assign push_o     = accept;
  assign deadzone_o = deadzone_q;

  always_comb begin
    mode_d       = mode_q;
    speed_gain_d = speed_gain_q;
    steer_gain_d = steer_gain_q;
    held_d       = held_q;
    led          = 1'b0;
    rise         = '0;
    mode_inc     = {1'b0, mode_q} + (gdcm_pkg::MODE_W + 1)'(1);
    if (in_data_i.connect_event) begin
      // Connect: back to the default mode, buttons left alone.
      mode_d = default_mode_q;
      led    = 1'b1;
    end else begin
      held_d = in_data_i.buttons;
      rise   = in_data_i.buttons & ~held_q;
      if (rise[gdcm_pkg::BTN_TOUCH]) begin
        mode_d = (mode_inc > {1'b0, mode_max_q}) ? default_mode_q
                                                 : mode_inc[gdcm_pkg::MODE_W-1:0];
        led    = 1'b1;
      end
      if (rise[gdcm_pkg::BTN_SPEED_UP]) begin
        speed_gain_d = gain_up(speed_gain_d, gain_step_q, gain_max_q);
      end
      if (rise[gdcm_pkg::BTN_SPEED_DOWN]) begin
        speed_gain_d = gain_down(speed_gain_d, gain_step_q, gain_min_q);
      end
      if (rise[gdcm_pkg::BTN_STEER_UP]) begin
        steer_gain_d = gain_up(steer_gain_d, gain_step_q, gain_max_q);
      end
      if (rise[gdcm_pkg::BTN_STEER_DOWN]) begin
        steer_gain_d = gain_down(steer_gain_d, gain_step_q, gain_min_q);
      end
    end
  end

  always_comb begin
    item_o.connect_event = in_data_i.connect_event;
    item_o.led_update    = led;
    item_o.mode          = mode_d;
    item_o.steer_gain    = steer_gain_d;
    item_o.speed_gain    = speed_gain_d;
    item_o.right_trigger = in_data_i.right_trigger;
    item_o.left_trigger  = in_data_i.left_trigger;
    item_o.right_x       = in_data_i.right_x;
    item_o.left_y        = in_data_i.left_y;
    item_o.left_x        = in_data_i.left_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q     <= gdcm_pkg::DEADZONE_RST;
      gain_step_q    <= gdcm_pkg::GAIN_STEP_RST;
      gain_min_q     <= gdcm_pkg::GAIN_MIN_RST;
      gain_max_q     <= gdcm_pkg::GAIN_MAX_RST;
      default_mode_q <= gdcm_pkg::DEFAULT_MODE_RST;
      mode_max_q     <= gdcm_pkg::MODE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gdcm_pkg::CFG_DEADZONE:     deadzone_q     <= cfg_wdata_i[gdcm_pkg::DEADZONE_W-1:0];
        gdcm_pkg::CFG_GAIN_STEP:    gain_step_q    <= cfg_wdata_i[gdcm_pkg::GAIN_STEP_W-1:0];
        gdcm_pkg::CFG_GAIN_MIN:     gain_min_q     <= cfg_wdata_i[gdcm_pkg::GAIN_W-1:0];
        gdcm_pkg::CFG_GAIN_MAX:     gain_max_q     <= cfg_wdata_i[gdcm_pkg::GAIN_W-1:0];
        gdcm_pkg::CFG_DEFAULT_MODE: default_mode_q <= cfg_wdata_i[gdcm_pkg::MODE_W-1:0];
        gdcm_pkg::CFG_MODE_MAX:     mode_max_q     <= cfg_wdata_i[gdcm_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= gdcm_pkg::DEFAULT_MODE_RST;
      speed_gain_q <= gdcm_pkg::GAIN_UNITY;
      steer_gain_q <= gdcm_pkg::GAIN_UNITY;
      held_q       <= '0;
    end else if (accept) begin
      mode_q       <= mode_d;
      speed_gain_q <= speed_gain_d;
      steer_gain_q <= steer_gain_d;
      held_q       <= held_d;
    end
  end

endmodule

/* rtl/core/gdcm_fifo.sv */
// Short queue of classified reports between the front end and the datapath.
`timescale 1ns / 1ps

module gdcm_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gdcm_pkg::gdcm_item_t item_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output gdcm_pkg::gdcm_item_t item_o
);

  gdcm_pkg::gdcm_item_t               mem_q [gdcm_pkg::FIFO_DEPTH];
  logic [gdcm_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [gdcm_pkg::FIFO_PTR_W:0]      count_q;

  assign full_o  = (count_q == (gdcm_pkg::FIFO_PTR_W + 1)'(gdcm_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + gdcm_pkg::FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + gdcm_pkg::FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (gdcm_pkg::FIFO_PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (gdcm_pkg::FIFO_PTR_W + 1)'(1);
      end
    end
  end

endmodule

/* rtl/core/gdcm_back.sv */
// Datapath: source selection, deadzone, trigger fallback, gain scaling, output register.
`timescale 1ns / 1ps
`include "gamepad_drive_command_mapper_macros.svh"

module gdcm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [gdcm_pkg::DEADZONE_W-1:0]  deadzone_i,
  input  logic                             fifo_empty_i,
  input  gdcm_pkg::gdcm_item_t             item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output gdcm_pkg::gdcm_result_t           result_o
);

  logic adv;

  // Stage 1: raw commands from the mode's source and from the triggers.
  logic                                 v1_q;
  gdcm_pkg::gdcm_meta_t                 meta1_q;
  logic signed [gdcm_pkg::RAW_W-1:0]    raw_st1_q, raw_sp1_q, trig_st1_q, trig_sp1_q;
  // Stage 2: final unscaled commands.
  logic                                 v2_q;
  gdcm_pkg::gdcm_meta_t                 meta2_q;
  logic signed [gdcm_pkg::RAW_W-1:0]    cmd_st2_q, cmd_sp2_q;
  // Stage 3: scaled magnitudes.
  logic                                 v3_q;
  gdcm_pkg::gdcm_meta_t                 meta3_q;
  logic [gdcm_pkg::PROD_W-1:0]          prod_st3_q, prod_sp3_q;
  logic                                 neg_st3_q, neg_sp3_q;
  // Output register.
  logic                                 out_valid_q;
  gdcm_pkg::gdcm_result_t               res_q;

  logic signed [7:0]                    st_src;
  logic signed [gdcm_pkg::RAW_W-1:0]    stick_st, stick_sp, trig_st, trig_sp;
  logic                                 lt_gt;
  logic [7:0]                           trig_diff, trig_max;
  logic [gdcm_pkg::MAG_W-1:0]           m_diff, m_max;
  logic signed [gdcm_pkg::RAW_W-1:0]    dz_st, dz_sp, fin_st, fin_sp;
  logic [gdcm_pkg::MAG_W-1:0]           mag_st, mag_sp;
  logic [gdcm_pkg::CMD_W-1:0]           out_st, out_sp;

  function automatic logic [gdcm_pkg::MAG_W-1:0] abs_cmd(
    input logic signed [gdcm_pkg::RAW_W-1:0] v
  );
    logic signed [gdcm_pkg::RAW_W-1:0] n;
    n = -v;
    return v[gdcm_pkg::RAW_W-1] ? n[gdcm_pkg::MAG_W-1:0] : v[gdcm_pkg::MAG_W-1:0];
  endfunction

  function automatic logic signed [gdcm_pkg::RAW_W-1:0] dz(
    input logic signed [gdcm_pkg::RAW_W-1:0] v,
    input logic [gdcm_pkg::DEADZONE_W-1:0]   thr
  );
    return (abs_cmd(v) < thr) ? '0 : v;
  endfunction

  function automatic gdcm_pkg::led_color_e color_of(input logic [gdcm_pkg::MODE_W-1:0] m);
    gdcm_pkg::led_color_e c;
    case (m)
      gdcm_pkg::MODE_DUAL_STICK: c = gdcm_pkg::LED_RED;
      gdcm_pkg::MODE_LEFT_STICK: c = gdcm_pkg::LED_GREEN;
      gdcm_pkg::MODE_TRIGGER:    c = gdcm_pkg::LED_BLUE;
      default:                   c = gdcm_pkg::LED_OFF;
    endcase
    return c;
  endfunction

  // The whole pipe advances together whenever the output register can take a result.
  assign adv         = !out_valid_q || out_ready_i;
  assign pop_o       = adv && !fifo_empty_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    st_src    = (item_i.mode == gdcm_pkg::MODE_LEFT_STICK) ? item_i.left_x : item_i.right_x;
    stick_st  = gdcm_pkg::map_stick(st_src);
    stick_sp  = -gdcm_pkg::map_stick(item_i.left_y);
    lt_gt     = item_i.left_trigger > item_i.right_trigger;
    trig_diff = lt_gt ? item_i.left_trigger - item_i.right_trigger
                      : item_i.right_trigger - item_i.left_trigger;
    trig_max  = lt_gt ? item_i.left_trigger : item_i.right_trigger;
    m_diff    = gdcm_pkg::trig_map(trig_diff);
    m_max     = gdcm_pkg::trig_map(trig_max);
    trig_st   = lt_gt ? -$signed({1'b0, m_diff}) : $signed({1'b0, m_diff});
    if (item_i.left_trigger > 8'(gdcm_pkg::TRIG_THRESHOLD) &&
        item_i.right_trigger > 8'(gdcm_pkg::TRIG_THRESHOLD)) begin
      trig_sp = -$signed({1'b0, m_max});
    end else begin
      trig_sp = '0;
    end
  end

  always_comb begin
    dz_st = dz(raw_st1_q, deadzone_i);
    dz_sp = dz(raw_sp1_q, deadzone_i);
    if (meta1_q.connect_event) begin
      fin_st = '0;
      fin_sp = '0;
    end else if (dz_st == '0 && dz_sp == '0) begin
      // Both dead: fall back to the triggers.
      fin_st = dz(trig_st1_q, deadzone_i);
      fin_sp = dz(trig_sp1_q, deadzone_i);
    end else begin
      fin_st = dz_st;
      fin_sp = dz_sp;
    end
  end

  assign mag_st = abs_cmd(cmd_st2_q);
  assign mag_sp = abs_cmd(cmd_sp2_q);

  // At most 500 * 4095 / 256, so the 16-bit command never saturates.
  always_comb begin
    out_st = {3'b000, prod_st3_q[gdcm_pkg::PROD_W-1:8]};
    out_sp = {3'b000, prod_sp3_q[gdcm_pkg::PROD_W-1:8]};
    if (neg_st3_q) begin
      out_st = -out_st;
    end
    if (neg_sp3_q) begin
      out_sp = -out_sp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta1_q.connect_event <= item_i.connect_event;
      meta1_q.led_update    <= item_i.led_update;
      meta1_q.mode          <= item_i.mode;
      meta1_q.steer_gain    <= item_i.steer_gain;
      meta1_q.speed_gain    <= item_i.speed_gain;
      raw_st1_q  <= (item_i.mode == gdcm_pkg::MODE_TRIGGER) ? trig_st : stick_st;
      raw_sp1_q  <= (item_i.mode == gdcm_pkg::MODE_TRIGGER) ? trig_sp : stick_sp;
      trig_st1_q <= trig_st;
      trig_sp1_q <= trig_sp;

      meta2_q   <= meta1_q;
      cmd_st2_q <= fin_st;
      cmd_sp2_q <= fin_sp;

      meta3_q    <= meta2_q;
      prod_st3_q <= gdcm_pkg::PROD_W'(mag_st) * gdcm_pkg::PROD_W'(meta2_q.steer_gain);
      prod_sp3_q <= gdcm_pkg::PROD_W'(mag_sp) * gdcm_pkg::PROD_W'(meta2_q.speed_gain);
      neg_st3_q  <= cmd_st2_q[gdcm_pkg::RAW_W-1];
      neg_sp3_q  <= cmd_sp2_q[gdcm_pkg::RAW_W-1];

      res_q.steer_cmd   <= out_st;
      res_q.speed_cmd   <= out_sp;
      res_q.drive_valid <= !meta3_q.connect_event;
      res_q.drive_mode  <= meta3_q.mode;
      res_q.led_update  <= meta3_q.led_update;
      res_q.led_color   <= color_of(meta3_q.mode);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= pop_o;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  `GDCM_ASSERT(a_connect_zero, (out_valid_q && !res_q.drive_valid) |-> (res_q.steer_cmd == '0 && res_q.speed_cmd == '0), "connect result carries a nonzero command")
  `GDCM_ASSERT(a_connect_led, (out_valid_q && !res_q.drive_valid) |-> res_q.led_update, "connect result without LED update")
  `GDCM_ASSERT(a_cmd_range, out_valid_q |-> ((res_q.steer_cmd[15:13] == 3'b000 || res_q.steer_cmd[15:13] == 3'b111) && (res_q.speed_cmd[15:13] == 3'b000 || res_q.speed_cmd[15:13] == 3'b111)), "scaled command out of range")
  `GDCM_ASSERT_NEXT(a_pop_enters, pop_o, v1_q, "popped report did not enter the pipe")

endmodule

/* rtl/core/gamepad_drive_command_mapper.sv */
// Top level of the gamepad drive command mapper.
`timescale 1ns / 1ps

// Gamepad drive command mapper.
// Input stream (s_axis): one gamepad report per transfer; tuser flags a
// controller connect. Output stream (m_axis): exactly one result per report,
// in order: signed steer and speed commands, current drive mode, LED color,
// and the drive_valid / led_update flags in tuser.
// Configuration: cfg_we_i writes register cfg_idx_i (deadzone, gain step,
// gain min, gain max, default mode, mode max); write only while
// no report is in flight. Unknown indexes are ignored.
// Pipe: queue write, source/trigger map, deadzone/fallback, gain multiply, output.
// Throughput: one report per cycle while the queue is not full; mode, gain
// and button state update in the accept cycle, so back-to-back reports see
// each other's button edges.
// Reset: mode 1, both gains 1.0 (256), buttons released, registers at their
// defaults, queue and pipe empty.
// Stall: while m_axis_tvalid is high and m_axis_tready low the result holds
// and the pipe freezes; reports keep landing in the four-deep queue until it
// fills, then s_axis_tready drops.
module gamepad_drive_command_mapper (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gdcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gdcm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // left_x, left_y, right_x, left_trigger, right_trigger, touch_button,
  // speed_up_button, speed_down_button, steer_up_button, steer_down_button, pad
  input  logic [47:0]                     s_axis_tdata,
  // connect_event
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // steer_cmd, speed_cmd, drive_mode, led_color, pad
  output logic [39:0]                     m_axis_tdata,
  // drive_valid, led_update
  output logic [1:0]                      m_axis_tuser
);

  gdcm_pkg::gdcm_report_t            report;
  gdcm_pkg::gdcm_item_t              push_item, head_item;
  gdcm_pkg::gdcm_result_t            result;
  logic                              push, pop, fifo_full, fifo_empty;
  logic [gdcm_pkg::DEADZONE_W-1:0]   deadzone;

  // Unpack the input transfer.
  always_comb begin
    report.left_x        = s_axis_tdata[7:0];
    report.left_y        = s_axis_tdata[15:8];
    report.right_x       = s_axis_tdata[23:16];
    report.left_trigger  = s_axis_tdata[31:24];
    report.right_trigger = s_axis_tdata[39:32];
    report.buttons       = s_axis_tdata[44:40];
    report.connect_event = s_axis_tuser;
  end

  gdcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (report),
    .in_ready_o  (s_axis_tready),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .item_o      (push_item),
    .deadzone_o  (deadzone)
  );

  gdcm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .item_o  (head_item)
  );

  gdcm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .deadzone_i   (deadzone),
    .fifo_empty_i (fifo_empty),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result)
  );

  // Pack the output transfer.
  assign m_axis_tdata = {3'b000, result.led_color, result.drive_mode,
                         result.speed_cmd, result.steer_cmd};
  assign m_axis_tuser = {result.led_update, result.drive_valid};

endmodule
